// File: rtl/core/ddo_pkg.sv
// Shared types, constants and the arctangent table for the odometry block.
`default_nettype none
package ddo_pkg;

   localparam int unsigned CORDIC_STEPS_DEF = 24;
   localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd5243;

   localparam int unsigned VelW  = 24;
   localparam int unsigned DtW   = 16;
   localparam int unsigned MulAW = 29;
   localparam int unsigned MulBW = 34;
   localparam int unsigned ProdW = MulAW + MulBW;
   localparam int unsigned AngW  = 32;
   localparam int unsigned MidW  = 35;
   localparam int unsigned CorW  = 33;
   localparam int unsigned PosW  = 48;
   localparam int unsigned StepW = 5;

   // angles in 2^-28 rad
   localparam logic signed [31:0] TWO_PI  = 32'sd1686629713;
   localparam logic signed [31:0] PI      = 32'sd843314857;
   localparam logic signed [31:0] HALF_PI = 32'sd421657428;
   localparam logic signed [31:0] CORDIC_K = 32'sd652032874;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_MUL_P,
      CMD_MUL_Q,
      CMD_MID,
      CMD_REDUCE,
      CMD_ROTATE,
      CMD_MUL_X,
      CMD_MUL_Y,
      CMD_COMMIT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [StepW-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic mid_ok;   // reduced angle lies in [-pi, pi]
   } status_type;

   // round(atan(2^-i) * 2^28)
   function automatic logic signed [31:0] atan_lut(input logic [StepW-1:0] idx);
      logic signed [31:0] val;
      case (idx)
         5'd0:  val = 32'sd210828714;
         5'd1:  val = 32'sd124459457;
         5'd2:  val = 32'sd65760959;
         5'd3:  val = 32'sd33381290;
         5'd4:  val = 32'sd16755422;
         5'd5:  val = 32'sd8385879;
         5'd6:  val = 32'sd4193963;
         5'd7:  val = 32'sd2097109;
         5'd8:  val = 32'sd1048571;
         5'd9:  val = 32'sd524287;
         5'd29: val = 32'sd1;
         5'd30: val = 32'sd0;
         5'd31: val = 32'sd0;
         default: val = 32'sd1 <<< (5'd28 - idx);
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/ddo_ctrl.sv
// Sequencer for the odometry datapath: handshakes, multiply order, CORDIC count.
`default_nettype none
module ddo_ctrl
   import ddo_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd,
   input  status_type status
);

   localparam int unsigned CntW = $clog2(CORDIC_STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_P, S_MUL_Q, S_MID, S_RED, S_ROT, S_MUL_X, S_MUL_Y, S_COMMIT
   } state_type;

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = CMD_NONE;
      cmd.step     = StepW'(cnt_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = CMD_LOAD;
               state_in = S_MUL_P;
            end
         end
         S_MUL_P: begin
            cmd.op   = CMD_MUL_P;
            state_in = S_MUL_Q;
         end
         S_MUL_Q: begin
            cmd.op   = CMD_MUL_Q;
            state_in = S_MID;
         end
         S_MID: begin
            cmd.op   = CMD_MID;
            state_in = S_RED;
         end
         S_RED: begin
            cmd.op = CMD_REDUCE;
            if (status.mid_ok) begin
               cnt_in   = '0;
               state_in = S_ROT;
            end
         end
         S_ROT: begin
            cmd.op = CMD_ROTATE;
            if (cnt_ff == CntW'(CORDIC_STEPS - 1)) begin
               state_in = S_MUL_X;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MUL_X: begin
            cmd.op   = CMD_MUL_X;
            state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            cmd.op   = CMD_MUL_Y;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.op       = CMD_COMMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before taken");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready while request in flight");
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == CMD_COMMIT |-> out_free)
      else $error("commit over a pending result");

endmodule
`default_nettype wire

// File: rtl/core/ddo_dpath.sv
// Odometry datapath: shared multiplier, angle reduction, CORDIC and pose registers.
`default_nettype none
module ddo_dpath
   import ddo_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  wire logic                   csr_wr_en,
   input  wire logic [DtW-1:0]         csr_wr_data,
   input  wire logic signed [VelW-1:0] req_velocity,
   input  wire logic signed [VelW-1:0] req_angular_rate,
   output logic signed [PosW-1:0]      rsp_pos_x,
   output logic signed [PosW-1:0]      rsp_pos_y,
   output logic signed [AngW-1:0]      rsp_heading,
   output logic signed [VelW-1:0]      rsp_vel_echo,
   output logic signed [VelW-1:0]      rsp_rate_echo
);

   logic [DtW-1:0]          dt_ff;
   logic signed [VelW-1:0]  vel_ff, rate_ff, vel_echo_ff, rate_echo_ff;
   logic signed [ProdW-1:0] prod_ff;
   logic signed [MulAW-1:0] d_ff;
   logic signed [MidW-1:0]  mid_ff;
   logic signed [AngW:0]    dtheta_ff;
   logic signed [CorW-1:0]  cx_ff, cy_ff;
   logic signed [AngW-1:0]  z_ff;
   logic                    flip_ff;
   logic signed [PosW-1:0]  dx_ff, x_acc_ff, y_acc_ff;
   logic signed [AngW-1:0]  theta_ff;

   logic signed [MulAW-1:0] mul_a;
   logic signed [MulBW-1:0] mul_b;
   logic signed [ProdW-1:0] prod;
   logic signed [ProdW:0]   prod_x, rnd8, rnd9, rnd12, rnd30;
   logic signed [MulBW-1:0] cos_v, sin_v;
   logic                    mid_above, mid_below;
   logic signed [MidW-1:0]  mid_in_range;
   logic signed [CorW-1:0]  xs, ys;
   logic signed [AngW-1:0]  atan_v;
   logic signed [AngW+1:0]  t0, t1, t2;

   assign cos_v = flip_ff ? -MulBW'(cx_ff) : MulBW'(cx_ff);
   assign sin_v = flip_ff ? -MulBW'(cy_ff) : MulBW'(cy_ff);

   always_comb begin
      case (cmd.op)
         CMD_MUL_P: begin
            mul_a = MulAW'(vel_ff);
            mul_b = $signed({{(MulBW-DtW){1'b0}}, dt_ff});
         end
         CMD_MUL_Q: begin
            mul_a = MulAW'(rate_ff);
            mul_b = $signed({{(MulBW-DtW){1'b0}}, dt_ff});
         end
         CMD_MUL_X: begin
            mul_a = d_ff;
            mul_b = cos_v;
         end
         default: begin
            mul_a = d_ff;
            mul_b = sin_v;
         end
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign prod_x = {prod_ff[ProdW-1], prod_ff};
   assign rnd8   = prod_x + (ProdW+1)'(1 << 7);
   assign rnd9   = prod_x + (ProdW+1)'(1 << 8);
   assign rnd12  = prod_x + (ProdW+1)'(1 << 11);
   assign rnd30  = prod_x + (ProdW+1)'(1 << 29);

   assign mid_above    = mid_ff > MidW'(PI);
   assign mid_below    = mid_ff < -MidW'(PI);
   assign status.mid_ok = !mid_above && !mid_below;
   assign mid_in_range = mid_ff;

   assign xs     = cx_ff >>> cmd.step;
   assign ys     = cy_ff >>> cmd.step;
   assign atan_v = atan_lut(cmd.step);

   // heading update with one correction each way
   assign t0 = (AngW+2)'(theta_ff) + (AngW+2)'(dtheta_ff);
   assign t1 = (t0 >= (AngW+2)'(TWO_PI)) ? t0 - (AngW+2)'(TWO_PI) : t0;
   assign t2 = (t1 <= -(AngW+2)'(TWO_PI)) ? t1 + (AngW+2)'(TWO_PI) : t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff    <= SAMPLE_PERIOD_RST;
         x_acc_ff <= '0;
         y_acc_ff <= '0;
         theta_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            dt_ff <= csr_wr_data;
         end
         if (cmd.op == CMD_COMMIT) begin
            x_acc_ff <= x_acc_ff + dx_ff;
            y_acc_ff <= y_acc_ff + PosW'($signed(rnd30[ProdW:30]));
            theta_ff <= t2[AngW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_LOAD: begin
            vel_ff  <= req_velocity;
            rate_ff <= req_angular_rate;
         end
         CMD_MUL_P: prod_ff <= prod;
         CMD_MUL_Q: begin
            prod_ff <= prod;
            d_ff    <= rnd12[12 +: MulAW];
         end
         CMD_MID: begin
            dtheta_ff <= rnd8[8 +: AngW+1];
            mid_ff    <= MidW'(theta_ff) + MidW'($signed(rnd9[9 +: AngW]));
         end
         CMD_REDUCE: begin
            if (mid_above) begin
               mid_ff <= mid_ff - MidW'(TWO_PI);
            end else if (mid_below) begin
               mid_ff <= mid_ff + MidW'(TWO_PI);
            end else begin
               cx_ff <= CorW'(CORDIC_K);
               cy_ff <= '0;
               if (mid_in_range > MidW'(HALF_PI)) begin
                  z_ff    <= AngW'(mid_in_range - MidW'(PI));
                  flip_ff <= 1'b1;
               end else if (mid_in_range < -MidW'(HALF_PI)) begin
                  z_ff    <= AngW'(mid_in_range + MidW'(PI));
                  flip_ff <= 1'b1;
               end else begin
                  z_ff    <= AngW'(mid_in_range);
                  flip_ff <= 1'b0;
               end
            end
         end
         CMD_ROTATE: begin
            if (!z_ff[AngW-1]) begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               z_ff  <= z_ff - atan_v;
            end else begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               z_ff  <= z_ff + atan_v;
            end
         end
         CMD_MUL_X: prod_ff <= prod;
         CMD_MUL_Y: begin
            prod_ff <= prod;
            dx_ff   <= PosW'($signed(rnd30[ProdW:30]));
         end
         CMD_COMMIT: begin
            vel_echo_ff  <= vel_ff;
            rate_echo_ff <= rate_ff;
         end
         default: ;
      endcase
   end

   assign rsp_pos_x     = x_acc_ff;
   assign rsp_pos_y     = y_acc_ff;
   assign rsp_heading   = theta_ff;
   assign rsp_vel_echo  = vel_echo_ff;
   assign rsp_rate_echo = rate_echo_ff;

   a_rot_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == CMD_ROTATE |-> status.mid_ok)
      else $error("rotation on unreduced angle");

endmodule
`default_nettype wire

// File: rtl/core/diff_drive_odometry.sv
// Top level of the differential-drive odometry pose integrator.
//
//  channel  | ports                               | direction | meaning
//  ---------+-------------------------------------+-----------+---------------------------
//  req      | req_valid/ready, velocity, ang rate | in        | one tick request (v, w)
//  rsp      | rsp_valid/ready, pos_x/y, heading.. | out       | pose after tick, v/w echo
//  csr      | csr_wr_en, csr_wr_data              | in        | sample period dt (2^-20 s)
//
// From accept to the next accept a request runs through two setup multiplies, a
// midpoint add, the angle reduction (repeated until the midpoint lies in [-pi, pi]),
// one CORDIC step per cycle on the single shift-add unit, two multiplies on the
// shared multiplier, the commit (which waits for a free output) and the idle state
// for the accept; one request is in flight at a time.
// Synchronous active-high reset clears the pose to zero and dt to 5243.
// A new request is taken while the last result still waits on rsp_ready; the
// commit of the next pose waits until that result has been taken.
`default_nettype none
module diff_drive_odometry
   import ddo_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic signed [VelW-1:0] req_velocity,
   input  wire logic signed [VelW-1:0] req_angular_rate,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [PosW-1:0]      rsp_pos_x,
   output logic signed [PosW-1:0]      rsp_pos_y,
   output logic signed [AngW-1:0]      rsp_heading,
   output logic signed [VelW-1:0]      rsp_vel_echo,
   output logic signed [VelW-1:0]      rsp_rate_echo,
   input  wire logic                   csr_wr_en,
   input  wire logic [DtW-1:0]         csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   // sequencing: handshakes, step count, commit gating
   ddo_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic and pose state
   ddo_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_velocity     (req_velocity),
      .req_angular_rate (req_angular_rate),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_heading      (rsp_heading),
      .rsp_vel_echo     (rsp_vel_echo),
      .rsp_rate_echo    (rsp_rate_echo)
   );

endmodule
`default_nettype wire

// File: tb/diff_drive_odometry_test.sv
// Self-checking testbench for the differential-drive odometry pose integrator.
`default_nettype none
module diff_drive_odometry_test;
   import ddo_pkg::*;

   localparam int unsigned STEPS = CORDIC_STEPS_DEF;
   localparam int unsigned SETTLE_CYCLES = STEPS + 30;
   localparam longint TWO_PI_L  = 64'sd1686629713;
   localparam longint PI_L      = 64'sd843314857;
   localparam longint HALF_PI_L = 64'sd421657428;
   localparam longint K_L       = 64'sd652032874;

   // what the stimulus queue can hold: a tick, a dt write, or a full drain
   typedef enum logic [1:0] {
      JOB_TICK,
      JOB_SET_DT,
      JOB_DRAIN
   } job_kind_type;

   typedef struct {
      job_kind_type      kind;
      logic [VelW-1:0]   vel;
      logic [VelW-1:0]   rate;
      logic [DtW-1:0]    dt;
   } job_type;

   typedef struct {
      logic [PosW-1:0] pos_x;
      logic [PosW-1:0] pos_y;
      logic [AngW-1:0] heading;
      logic [VelW-1:0] vel;
      logic [VelW-1:0] rate;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [VelW-1:0] req_velocity = '0;
   logic signed [VelW-1:0] req_angular_rate = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [PosW-1:0] rsp_pos_x;
   logic signed [PosW-1:0] rsp_pos_y;
   logic signed [AngW-1:0] rsp_heading;
   logic signed [VelW-1:0] rsp_vel_echo;
   logic signed [VelW-1:0] rsp_rate_echo;
   logic csr_wr_en = 1'b0;
   logic [DtW-1:0] csr_wr_data = '0;

   job_type   jobs[$];
   pose_type  pending_poses[$];
   int        error_count = 0;
   int        poses_seen = 0;

   // predictor state: own copy of the pose and of dt
   longint model_x, model_y, model_theta;
   longint model_dt;
   longint atan_tab[32];

   diff_drive_odometry dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_velocity     (req_velocity),
      .req_angular_rate (req_angular_rate),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_heading      (rsp_heading),
      .rsp_vel_echo     (rsp_vel_echo),
      .rsp_rate_echo    (rsp_rate_echo),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // arctangent table from the alternating series (entry 0 fixed), rounded to 2^-28 rad
   function automatic void fill_atan_tab();
      longint acc, term;
      int unsigned e;
      atan_tab[0] = 64'sd210828714;
      for (int unsigned i = 1; i < 32; i++) begin
         acc = 0;
         for (int unsigned k = 0; ; k++) begin
            e = i * (2 * k + 1);
            if (e > 60) break;
            term = (64'sd1 <<< (60 - e)) / longint'(2 * k + 1);
            acc += (k % 2 == 1) ? -term : term;
         end
         atan_tab[i] = (acc + (64'sd1 <<< 31)) >>> 32;
      end
   endfunction

   function automatic longint round_shift(longint a, int unsigned s);
      return (a + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // rotation-mode CORDIC with quadrant fold; Q30 outputs
   function automatic void sin_cos(longint ang, output longint c, output longint s);
      longint x, y, xs, ys;
      bit flip;
      flip = 1'b0;
      while (ang > PI_L) ang -= TWO_PI_L;
      while (ang < -PI_L) ang += TWO_PI_L;
      if (ang > HALF_PI_L) begin
         ang -= PI_L;
         flip = 1'b1;
      end else if (ang < -HALF_PI_L) begin
         ang += PI_L;
         flip = 1'b1;
      end
      x = K_L;
      y = 0;
      for (int unsigned i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (ang >= 0) begin
            x -= ys;
            y += xs;
            ang -= atan_tab[i % 32];
         end else begin
            x += ys;
            y -= xs;
            ang += atan_tab[i % 32];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // one odometry tick: advance the predicted pose and return it
   function automatic pose_type advance_pose(logic signed [VelW-1:0] v,
                                             logic signed [VelW-1:0] w);
      longint p, q, dtheta, half, c, s, d, t;
      logic signed [PosW-1:0] nx, ny;
      logic signed [AngW-1:0] nt;
      pose_type r;
      p = longint'(v) * model_dt;
      q = longint'(w) * model_dt;
      dtheta = round_shift(q, 8);
      half = round_shift(q, 9);
      sin_cos(model_theta + half, c, s);
      d = round_shift(p, 12);
      nx = PosW'(model_x + round_shift(d * c, 30));
      ny = PosW'(model_y + round_shift(d * s, 30));
      model_x = longint'(nx);
      model_y = longint'(ny);
      t = model_theta + dtheta;
      // one correction each way, then plain 32-bit wrap
      if (t >= TWO_PI_L) t -= TWO_PI_L;
      if (t <= -TWO_PI_L) t += TWO_PI_L;
      nt = AngW'(t);
      model_theta = longint'(nt);
      r.pos_x = nx;
      r.pos_y = ny;
      r.heading = nt;
      r.vel = v;
      r.rate = w;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on pose %0d: %s got %h want %h", poses_seen, what, got, want);
      error_count++;
   endtask

   // request driver
   int unsigned send_gap = 0;
   bit quiet_sender = 1'b0;
   always @(posedge clock) begin
      bit accepted;
      bit nxt_valid;
      bit nxt_wr;
      job_type j;
      accepted = req_valid && req_ready;
      nxt_valid = req_valid && !accepted;
      nxt_wr = 1'b0;
      if (!reset) begin
         if (accepted)
            pending_poses.push_back(advance_pose(req_velocity, req_angular_rate));
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (jobs.size() > 0) begin
               j = jobs[0];
               case (j.kind)
                  JOB_TICK: begin
                     req_velocity <= j.vel;
                     req_angular_rate <= j.rate;
                     nxt_valid = 1'b1;
                     void'(jobs.pop_front());
                     if (quiet_sender || $urandom_range(0, 3) != 0)
                        send_gap = 0;
                     else if ($urandom_range(0, 9) < 8)
                        send_gap = $urandom_range(1, 3);
                     else
                        send_gap = $urandom_range(10, 40);
                  end
                  JOB_SET_DT: begin
                     // write dt only when nothing is in flight
                     if (pending_poses.size() == 0 && !accepted) begin
                        csr_wr_data <= j.dt;
                        nxt_wr = 1'b1;
                        model_dt = longint'(j.dt);
                        void'(jobs.pop_front());
                     end
                  end
                  default: begin
                     if (pending_poses.size() == 0 && !accepted)
                        void'(jobs.pop_front());
                  end
               endcase
            end
         end
      end
      req_valid <= nxt_valid;
      csr_wr_en <= nxt_wr;
   end

   // result monitor and receiver backpressure
   int unsigned recv_gap = 0;
   int unsigned long_hold = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      pose_type e;
      bit nxt_ready;
      nxt_ready = rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_poses.size() == 0) begin
               report_mismatch("unexpected pose", 64'(rsp_pos_x), '0);
            end else begin
               e = pending_poses.pop_front();
               if (rsp_pos_x !== e.pos_x)
                  report_mismatch("pos_x", 64'(rsp_pos_x), 64'(e.pos_x));
               if (rsp_pos_y !== e.pos_y)
                  report_mismatch("pos_y", 64'(rsp_pos_y), 64'(e.pos_y));
               if (rsp_heading !== e.heading)
                  report_mismatch("heading", 64'(rsp_heading), 64'(e.heading));
               if (rsp_vel_echo !== e.vel)
                  report_mismatch("vel_echo", 64'(rsp_vel_echo), 64'(e.vel));
               if (rsp_rate_echo !== e.rate)
                  report_mismatch("rate_echo", 64'(rsp_rate_echo), 64'(e.rate));
            end
            poses_seen++;
         end
         // one long hold-off so the block backs up and stalls requests
         if (!hold_done && poses_seen == 300) begin
            hold_done = 1'b1;
            long_hold = 600;
         end
         if (long_hold > 0) begin
            long_hold--;
            nxt_ready = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            nxt_ready = 1'b0;
         end else begin
            nxt_ready = 1'b1;
            if (poses_seen > 1200 && poses_seen < 1500)
               recv_gap = 0;       // stretch with no stalls
            else if ($urandom_range(0, 4) == 0)
               recv_gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                      : $urandom_range(10, 50);
         end
      end
      rsp_ready <= nxt_ready;
   end

   task automatic add_tick(logic [VelW-1:0] v, logic [VelW-1:0] w);
      job_type j;
      j.kind = JOB_TICK;
      j.vel = v;
      j.rate = w;
      j.dt = '0;
      jobs.push_back(j);
   endtask

   task automatic add_dt(logic [DtW-1:0] dt);
      job_type j;
      j.kind = JOB_SET_DT;
      j.vel = '0;
      j.rate = '0;
      j.dt = dt;
      jobs.push_back(j);
   endtask

   task automatic add_drain();
      job_type j;
      j.kind = JOB_DRAIN;
      j.vel = '0;
      j.rate = '0;
      j.dt = '0;
      jobs.push_back(j);
   endtask

   function automatic logic [VelW-1:0] pick_field();
      case ($urandom_range(0, 5))
         0: return 24'($urandom());                             // full range
         1: return 24'($signed($urandom_range(0, 2000)) - 1000);
         2: return ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
         default: return 24'($signed($urandom_range(0, 400000)) - 200000);
      endcase
   endfunction

   initial begin
      logic [DtW-1:0] dt_list[8];
      model_x = 0;
      model_y = 0;
      model_theta = 0;
      model_dt = longint'(SAMPLE_PERIOD_RST);
      fill_atan_tab();
      dt_list = '{16'd1, 16'd65535, 16'd0, 16'd5243, 16'd100, 16'd40000,
                  16'd20000, 16'd65535};

      // directed: field extremes at reset dt, then dt extremes and zero dt
      add_tick(24'h000000, 24'h000000);
      add_tick(24'h7FFFFF, 24'h000000);
      add_tick(24'h800000, 24'h000000);
      add_tick(24'h7FFFFF, 24'h7FFFFF);
      add_tick(24'h800000, 24'h800000);
      add_tick(24'h000001, 24'hFFFFFF);
      add_tick(24'hFFFFFF, 24'h000001);
      add_drain();
      add_dt(16'd65535);
      // large turns at max dt push the heading past both wrap limits
      add_tick(24'h7FFFFF, 24'h7FFFFF);
      add_tick(24'h7FFFFF, 24'h7FFFFF);
      add_tick(24'h800000, 24'h800000);
      add_tick(24'h800000, 24'h800000);
      add_tick(24'h800000, 24'h800000);
      add_tick(24'h123456, 24'h7FFFFF);
      add_drain();
      add_dt(16'd0);
      add_tick(24'h7FFFFF, 24'h7FFFFF);
      add_tick(24'h800000, 24'h123456);
      add_drain();
      add_dt(16'd1);
      add_tick(24'h7FFFFF, 24'h800000);
      add_tick(24'h555555, 24'hAAAAAA);
      add_drain();

      // random phases across several dt settings
      for (int ph = 0; ph < 8; ph++) begin
         add_dt(dt_list[ph]);
         for (int n = 0; n < 235; n++)
            add_tick(pick_field(), pick_field());
         add_drain();
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (jobs.size() > 0 || req_valid || pending_poses.size() > 0) begin
         quiet_sender = (jobs.size() > 600 && jobs.size() < 800);
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_poses.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #30000000;
      $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire

// File: diff_drive_odometry.f
rtl/core/ddo_pkg.sv
rtl/core/ddo_ctrl.sv
rtl/core/ddo_dpath.sv
rtl/core/diff_drive_odometry.sv
tb/diff_drive_odometry_test.sv
